[hw/rtl/tblp_pkg.sv]
// Shared types and constants for the tap, burst and long-press classifier.
package tblp_pkg;

  // Register reset values and counting limits.
  localparam logic [15:0] LONG_PRESS_MS_RESET = 16'd800;
  localparam logic [15:0] TAP_GAP_MS_RESET    = 16'd180;
  localparam logic [7:0]  BURST_AT_ONCE       = 8'd3;
  localparam logic [7:0]  COUNT_MAX           = 8'd255;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 3;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_LONG_PRESS_MS = 1'b0,
    REG_TAP_GAP_MS    = 1'b1
  } reg_index_t;

  // Gesture codes.
  typedef enum logic [1:0] {
    GESTURE_NONE  = 2'd0,
    GESTURE_TAP   = 2'd1,
    GESTURE_BURST = 2'd2,
    GESTURE_LONG  = 2'd3
  } gesture_t;

  // Current configuration handed to the classifier.
  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] tap_gap_ms;
  } cfg_t;

  // One classification result.
  typedef struct packed {
    gesture_t    gesture;
    logic [7:0]  tap_count;
  } result_t;

endpackage

[hw/rtl/tblp_cfg.sv]
// APB-style configuration registers for the classifier.
module tblp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tblp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output tblp_pkg::cfg_t                  cfg
);
  import tblp_pkg::*;

  logic       wr_en;
  reg_index_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = reg_index_t'(paddr[2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms <= LONG_PRESS_MS_RESET;
      cfg.tap_gap_ms    <= TAP_GAP_MS_RESET;
    end else if (wr_en) begin
      unique case (sel)
        REG_LONG_PRESS_MS: cfg.long_press_ms <= pwdata[15:0];
        REG_TAP_GAP_MS:    cfg.tap_gap_ms    <= pwdata[15:0];
        default:           ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (sel)
      REG_LONG_PRESS_MS: prdata = {16'd0, cfg.long_press_ms};
      REG_TAP_GAP_MS:    prdata = {16'd0, cfg.tap_gap_ms};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/tblp_core.sv]
// Classification logic and button history state.
module tblp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  logic             level,
  input  logic [31:0]      now,
  input  tblp_pkg::cfg_t   cfg,
  output tblp_pkg::result_t result
);
  import tblp_pkg::*;

  logic        level_prev;
  logic [31:0] press_time;
  logic [31:0] release_time;
  logic [7:0]  burst_taps;
  logic        burst_reported;
  logic        long_reported;

  logic        level_prev_next;
  logic [31:0] press_time_next;
  logic [31:0] release_time_next;
  logic [7:0]  burst_taps_next;
  logic        burst_reported_next;
  logic        long_reported_next;

  logic        press_edge;
  logic        release_edge;
  logic [31:0] held;
  logic [31:0] gap;
  logic        long_hit;
  logic        gap_hit;

  assign press_edge   = level & ~level_prev;
  assign release_edge = ~level & level_prev;

  // Edge handling, then the long-press check, then the end-of-burst check.
  always_comb begin
    result.gesture      = GESTURE_NONE;
    result.tap_count    = 8'd0;
    press_time_next     = press_time;
    release_time_next   = release_time;
    burst_taps_next     = burst_taps;
    burst_reported_next = burst_reported;
    long_reported_next  = long_reported;
    level_prev_next     = level;

    if (press_edge) begin
      press_time_next    = now;
      long_reported_next = 1'b0;
      if (burst_taps != COUNT_MAX) begin
        burst_taps_next = burst_taps + 8'd1;
      end
      if (burst_taps_next >= BURST_AT_ONCE) begin
        result.gesture      = GESTURE_BURST;
        result.tap_count    = burst_taps_next;
        burst_reported_next = 1'b1;
      end
    end else if (release_edge && !long_reported) begin
      release_time_next = now;
    end

    held     = now - press_time_next;
    long_hit = level & ~long_reported_next & (held >= {16'd0, cfg.long_press_ms});
    if (long_hit) begin
      result.gesture      = GESTURE_LONG;
      result.tap_count    = 8'd0;
      long_reported_next  = 1'b1;
      burst_taps_next     = 8'd0;
      burst_reported_next = 1'b0;
    end

    gap     = now - release_time_next;
    gap_hit = ~level & (burst_taps_next != 8'd0) & (gap >= {16'd0, cfg.tap_gap_ms});
    if (gap_hit) begin
      // Only an uncommitted burst of one or two presses is reported here.
      if (!burst_reported_next) begin
        if (burst_taps_next == 8'd1) begin
          result.gesture   = GESTURE_TAP;
          result.tap_count = 8'd0;
        end else if (burst_taps_next == 8'd2) begin
          result.gesture   = GESTURE_BURST;
          result.tap_count = 8'd2;
        end
      end
      burst_taps_next     = 8'd0;
      burst_reported_next = 1'b0;
    end
  end

  // History state advances once per classified request.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_prev     <= 1'b0;
      press_time     <= 32'd0;
      release_time   <= 32'd0;
      burst_taps     <= 8'd0;
      burst_reported <= 1'b0;
      long_reported  <= 1'b0;
    end else if (update) begin
      level_prev     <= level_prev_next;
      press_time     <= press_time_next;
      release_time   <= release_time_next;
      burst_taps     <= burst_taps_next;
      burst_reported <= burst_reported_next;
      long_reported  <= long_reported_next;
    end
  end

endmodule

[hw/rtl/tap_burst_long_press_classifier.sv]
// Top level of the tap, burst and long-press classifier.
// Takes one button sample (level and millisecond time) per request and returns one
// gesture result per request. A new request is taken every cycle unless stalled;
// each request is held in the input register and then in the result register, with
// the classification done between them. The result register lets the input side
// keep accepting while a result waits, and the input stalls only when both registers
// are full and the output is stalled. Register writes must happen while no request
// is in flight.
module tap_burst_long_press_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            button_level,
  input  logic [31:0]                     now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      gesture,
  output logic [7:0]                      tap_count,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tblp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tblp_pkg::*;

  cfg_t        cfg;
  result_t     result;
  logic        s1_valid;
  logic        s1_level;
  logic [31:0] s1_now;
  logic        advance;
  logic        accept;

  tblp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tblp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .level  (s1_level),
    .now    (s1_now),
    .cfg    (cfg),
    .result (result)
  );

  // Pipeline flow control.
  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_level <= button_level;
      s1_now   <= now_ms;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture   <= result.gesture;
      tap_count <= result.tap_count;
    end
  end

endmodule
